// ----- rtl/core/sql_cms_pkg.sv -----
// ----------------------------------------------------------------------------
// SQL comment marker scanner package
// Character codes, the marker text and the character class record.
// ----------------------------------------------------------------------------
package sql_cms_pkg;

    localparam int CODE_W     = 16;
    localparam int MARKER_LEN = 15;
    localparam int POS_W      = $clog2(MARKER_LEN);

    localparam logic [CODE_W-1:0] CH_DASH    = 16'h002D;
    localparam logic [CODE_W-1:0] CH_SLASH   = 16'h002F;
    localparam logic [CODE_W-1:0] CH_STAR    = 16'h002A;
    localparam logic [CODE_W-1:0] CH_QUOTE   = 16'h0027;
    localparam logic [CODE_W-1:0] CH_BSLASH  = 16'h005C;
    localparam logic [CODE_W-1:0] CH_NEWLINE = 16'h000A;
    localparam logic [CODE_W-1:0] CH_LBRACK  = 16'h005B;

    // "[IGNORE-ERRORS]"
    localparam logic [7:0] MARKER_TEXT [MARKER_LEN] = '{
        8'h5B, 8'h49, 8'h47, 8'h4E, 8'h4F, 8'h52, 8'h45, 8'h2D,
        8'h45, 8'h52, 8'h52, 8'h4F, 8'h52, 8'h53, 8'h5D
    };

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              is_dash;
        logic              is_slash;
        logic              is_star;
        logic              is_quote;
        logic              is_bslash;
        logic              is_newline;
        logic              is_lbrack;
    } char_class_t;

    typedef struct packed {
        logic found_next;
        logic at_reset;
    } scan_status_t;

endpackage

// ----- rtl/core/sql_cms_decode.sv -----
// ----------------------------------------------------------------------------
// Character classifier
// Masks the code to the active character width and flags the special
// characters that drive the lexical state machine.
// ----------------------------------------------------------------------------
module sql_cms_decode #(
    parameter int CHAR_WIDTH = 16
) (
    input  logic [15:0]              char_code,
    output sql_cms_pkg::char_class_t char_class
);
    import sql_cms_pkg::*;

    logic [CODE_W-1:0] code_mask;
    logic [CODE_W-1:0] code;

    always_comb begin
        for (int i = 0; i < CODE_W; i++) begin
            code_mask[i] = (i < CHAR_WIDTH);
        end
    end

    assign code = char_code & code_mask;

    always_comb begin
        char_class.code       = code;
        char_class.is_dash    = (code == CH_DASH);
        char_class.is_slash   = (code == CH_SLASH);
        char_class.is_star    = (code == CH_STAR);
        char_class.is_quote   = (code == CH_QUOTE);
        char_class.is_bslash  = (code == CH_BSLASH);
        char_class.is_newline = (code == CH_NEWLINE);
        char_class.is_lbrack  = (code == CH_LBRACK);
    end

endmodule

// ----- rtl/core/sql_cms_scan.sv -----
// ----------------------------------------------------------------------------
// Lexical scanner
// Tracks text, literal and comment context with one character of lookahead
// and matches the marker inside comments. State resets after the last char.
// ----------------------------------------------------------------------------
module sql_cms_scan (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      step,
    input  logic                      is_last,
    input  sql_cms_pkg::char_class_t  char_class,
    output sql_cms_pkg::scan_status_t status
);
    import sql_cms_pkg::*;

    typedef enum logic [3:0] {
        MODE_NORMAL,
        MODE_NORM_DASH,
        MODE_NORM_SLASH,
        MODE_LITERAL,
        MODE_LIT_ESCAPE,
        MODE_LIT_QUOTE,
        MODE_LINE,
        MODE_BLOCK,
        MODE_BLOCK_STAR
    } mode_t;

    mode_t            mode_reg, mode_next, mode_mid;
    logic [POS_W-1:0] pos_reg, pos_next, pos_mid, pos_idx;
    logic             found_reg, found_next;
    logic             consumed;
    logic             marker_hit;

    assign pos_idx    = (pos_reg < POS_W'(MARKER_LEN)) ? pos_reg : '0;
    assign marker_hit = (pos_reg < POS_W'(MARKER_LEN)) &&
                        (char_class.code == {{(CODE_W-8){1'b0}}, MARKER_TEXT[pos_idx]});

    always_comb begin
        mode_mid = mode_reg;
        pos_mid  = pos_reg;
        consumed = 1'b0;
        // resolve a pending pair first
        case (mode_reg)
            MODE_NORM_DASH: begin
                if (char_class.is_dash) begin
                    mode_mid = MODE_LINE;
                    pos_mid  = '0;
                    consumed = 1'b1;
                end else begin
                    mode_mid = MODE_NORMAL;
                end
            end
            MODE_NORM_SLASH: begin
                if (char_class.is_star) begin
                    mode_mid = MODE_BLOCK;
                    pos_mid  = '0;
                    consumed = 1'b1;
                end else begin
                    mode_mid = MODE_NORMAL;
                end
            end
            MODE_LIT_ESCAPE: begin
                mode_mid = MODE_LITERAL;
                consumed = 1'b1;
            end
            MODE_LIT_QUOTE: begin
                if (char_class.is_quote) begin
                    mode_mid = MODE_LITERAL;
                    consumed = 1'b1;
                end else begin
                    mode_mid = MODE_NORMAL;
                end
            end
            MODE_BLOCK_STAR: begin
                if (char_class.is_slash) begin
                    mode_mid = MODE_NORMAL;
                    pos_mid  = '0;
                    consumed = 1'b1;
                end else begin
                    mode_mid = MODE_BLOCK;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        mode_next  = mode_mid;
        pos_next   = pos_mid;
        found_next = found_reg;
        if (!consumed) begin
            case (mode_mid)
                MODE_LITERAL: begin
                    if (char_class.is_bslash) begin
                        mode_next = MODE_LIT_ESCAPE;
                    end else if (char_class.is_quote) begin
                        mode_next = MODE_LIT_QUOTE;
                    end
                end
                MODE_LINE, MODE_BLOCK: begin
                    if (mode_mid == MODE_LINE && char_class.is_newline) begin
                        mode_next = MODE_NORMAL;
                        pos_next  = '0;
                    end else if (mode_mid == MODE_BLOCK && char_class.is_star) begin
                        mode_next = MODE_BLOCK_STAR;
                        pos_next  = '0;
                    end else if (marker_hit) begin
                        if (pos_mid == POS_W'(MARKER_LEN - 1)) begin
                            found_next = 1'b1;
                            pos_next   = '0;
                        end else begin
                            pos_next = pos_mid + 1'b1;
                        end
                    end else begin
                        // restart on a fresh bracket
                        pos_next = char_class.is_lbrack ? POS_W'(1) : '0;
                    end
                end
                default: begin
                    mode_next = MODE_NORMAL;
                    if (char_class.is_quote) begin
                        mode_next = MODE_LITERAL;
                    end else if (char_class.is_dash) begin
                        mode_next = MODE_NORM_DASH;
                    end else if (char_class.is_slash) begin
                        mode_next = MODE_NORM_SLASH;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_NORMAL;
            pos_reg   <= '0;
            found_reg <= 1'b0;
        end else if (step) begin
            if (is_last) begin
                mode_reg  <= MODE_NORMAL;
                pos_reg   <= '0;
                found_reg <= 1'b0;
            end else begin
                mode_reg  <= mode_next;
                pos_reg   <= pos_next;
                found_reg <= found_next;
            end
        end
    end

    assign status.found_next = found_next;
    assign status.at_reset   = (mode_reg == MODE_NORMAL) && (pos_reg == '0) && !found_reg;

endmodule

// ----- rtl/core/sql_comment_marker_scanner_unit.sv -----
// ----------------------------------------------------------------------------
// SQL comment marker scanner
// Streams SQL text one character per request and reports whether the
// [IGNORE-ERRORS] marker appeared inside a comment of the statement.
// ----------------------------------------------------------------------------
// The block takes one character per clock cycle unless the input stalls.
// Each character is captured in an input register and scanned from there;
// the lexical state and the result register update together as it is scanned.
// The input only stalls while the result of one statement is still waiting
// in the output register and the last character of the next statement is
// ready to scan.
module sql_comment_marker_scanner_unit #(
    parameter int CHAR_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_char_code,
    input  logic        s_is_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_marker_found
);
    import sql_cms_pkg::*;

    logic         in_valid_reg;
    logic [15:0]  in_code_reg;
    logic         in_last_reg;
    logic         out_valid_reg;
    logic         out_found_reg;
    logic         advance;
    char_class_t  char_class;
    scan_status_t status;

    assign advance = in_valid_reg && (!in_last_reg || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_code_reg <= s_char_code;
            in_last_reg <= s_is_last;
        end
    end

    sql_cms_decode #(
        .CHAR_WIDTH (CHAR_WIDTH)
    ) u_decode (
        .char_code  (in_code_reg),
        .char_class (char_class)
    );

    sql_cms_scan u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .is_last    (in_last_reg),
        .char_class (char_class),
        .status     (status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            out_found_reg <= status.found_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_marker_found = out_found_reg;

    // scanner returns to its reset state after each statement
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_last_reg) |=> status.at_reset)
        else $error("scanner state not cleared after last character");

    // a result appears only after a last character was scanned
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(advance && in_last_reg))
        else $error("result without a last character");

    // the input stalls only behind a held result
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && in_last_reg && out_valid_reg && !m_ready))
        else $error("input stalled without a pending result");

endmodule

// ----- tb/sql_comment_marker_scanner_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SQL comment marker scanner testbench
// Streams directed and random SQL statements one character per request,
// predicts the marker verdict of each statement with a local lexer model and
// compares every returned verdict in order, under random stalls on both sides.
// ----------------------------------------------------------------------------
module sql_comment_marker_scanner_unit_test;

    import sql_cms_pkg::*;

    localparam int TARGET_CHARS = 1100;
    localparam int TAIL_CHARS   = 150;
    localparam int LONG_HOLD    = 250;
    localparam int CYCLE_LIMIT  = 300000;

    typedef enum logic [3:0] {
        LX_NORMAL,
        LX_DASH,
        LX_SLASH,
        LX_QUOTED,
        LX_ESCAPE,
        LX_QUOTE_END,
        LX_LINE,
        LX_BLOCK,
        LX_BLOCK_STAR
    } lex_mode_t;

    typedef struct {
        logic [CODE_W-1:0] code;
        logic              last;
        bit                drain_first;
    } char_request_t;

    logic              aclk           = 1'b0;
    logic              aresetn        = 1'b0;
    logic              s_valid        = 1'b0;
    logic              s_ready;
    logic [15:0]       s_char_code    = '0;
    logic              s_is_last      = 1'b0;
    logic              m_valid;
    logic              m_ready        = 1'b0;
    logic              m_marker_found;

    char_request_t     pending_chars[$];
    logic [CODE_W-1:0] stmt_chars[$];
    bit                marker_verdicts[$];

    // lexer model state
    lex_mode_t         lex_mode    = LX_NORMAL;
    int                marker_pos  = 0;
    bit                marker_seen = 1'b0;

    int                total_chars    = 0;
    int                chars_accepted = 0;
    int                verdicts_seen  = 0;
    int                mismatch_count = 0;
    int                cycle_count    = 0;
    int                gap_left       = 0;
    int                gap_pct        = 20;
    int                stall_left     = 0;
    int                stall_pct      = 20;
    int                hold_left      = 0;
    bit                hold_done      = 1'b0;
    logic              winding_down   = 1'b0;

    sql_comment_marker_scanner_unit u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_char_code    (s_char_code),
        .s_is_last      (s_is_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_marker_found (m_marker_found)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Lexer model
    // ------------------------------------------------------------------
    function automatic void follow_marker(input logic [CODE_W-1:0] c);
        if (marker_pos < MARKER_LEN && c == CODE_W'(MARKER_TEXT[marker_pos])) begin
            marker_pos++;
            if (marker_pos >= MARKER_LEN) begin
                marker_seen = 1'b1;
                marker_pos  = 0;
            end
        end else begin
            marker_pos = (c == CH_LBRACK) ? 1 : 0;
        end
    endfunction

    function automatic void scan_sql_char(input logic [CODE_W-1:0] c, input logic last);
        bit resolved;
        resolved = 1'b0;
        // settle a pending pair first; an unfinished pair falls back and rescans c
        case (lex_mode)
            LX_DASH: begin
                if (c == CH_DASH) begin
                    lex_mode   = LX_LINE;
                    marker_pos = 0;
                    resolved   = 1'b1;
                end else begin
                    lex_mode = LX_NORMAL;
                end
            end
            LX_SLASH: begin
                if (c == CH_STAR) begin
                    lex_mode   = LX_BLOCK;
                    marker_pos = 0;
                    resolved   = 1'b1;
                end else begin
                    lex_mode = LX_NORMAL;
                end
            end
            LX_ESCAPE: begin
                lex_mode = LX_QUOTED;
                resolved = 1'b1;
            end
            LX_QUOTE_END: begin
                if (c == CH_QUOTE) begin
                    lex_mode = LX_QUOTED;
                    resolved = 1'b1;
                end else begin
                    lex_mode = LX_NORMAL;
                end
            end
            LX_BLOCK_STAR: begin
                if (c == CH_SLASH) begin
                    lex_mode   = LX_NORMAL;
                    marker_pos = 0;
                    resolved   = 1'b1;
                end else begin
                    lex_mode = LX_BLOCK;
                end
            end
            default: ;
        endcase
        if (!resolved) begin
            case (lex_mode)
                LX_QUOTED: begin
                    if (c == CH_BSLASH)
                        lex_mode = LX_ESCAPE;
                    else if (c == CH_QUOTE)
                        lex_mode = LX_QUOTE_END;
                end
                LX_LINE: begin
                    if (c == CH_NEWLINE) begin
                        lex_mode   = LX_NORMAL;
                        marker_pos = 0;
                    end else begin
                        follow_marker(c);
                    end
                end
                LX_BLOCK: begin
                    if (c == CH_STAR) begin
                        lex_mode   = LX_BLOCK_STAR;
                        marker_pos = 0;
                    end else begin
                        follow_marker(c);
                    end
                end
                default: begin
                    if (c == CH_QUOTE)
                        lex_mode = LX_QUOTED;
                    else if (c == CH_DASH)
                        lex_mode = LX_DASH;
                    else if (c == CH_SLASH)
                        lex_mode = LX_SLASH;
                    else
                        lex_mode = LX_NORMAL;
                end
            endcase
        end
        if (last) begin
            marker_verdicts.push_back(marker_seen);
            lex_mode    = LX_NORMAL;
            marker_pos  = 0;
            marker_seen = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Statement building
    // ------------------------------------------------------------------
    task automatic put_code(input logic [CODE_W-1:0] c);
        stmt_chars.push_back(c);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            stmt_chars.push_back(CODE_W'(s[i]));
    endtask

    task automatic put_marker(input int n);
        for (int i = 0; i < n; i++)
            stmt_chars.push_back(CODE_W'(MARKER_TEXT[i]));
    endtask

    task automatic put_comment_body(input bit in_block);
        string filler;
        filler = "abzAZ09 [-]_=ERS";
        repeat ($urandom_range(0, 4)) begin
            case ($urandom_range(0, 7))
                0, 1: put_marker(MARKER_LEN);
                2: put_marker($urandom_range(1, MARKER_LEN - 1));
                3: begin
                    put_code(CH_LBRACK);
                    put_marker(MARKER_LEN);
                end
                4: put_text("[ignore-errors]");
                5: begin
                    // marker character with upper bits set must not match
                    put_marker($urandom_range(0, MARKER_LEN - 1));
                    put_code({8'($urandom_range(1, 255)),
                              MARKER_TEXT[$urandom_range(0, MARKER_LEN - 1)]});
                end
                6: repeat ($urandom_range(1, 5))
                    put_code(CODE_W'(filler[$urandom_range(0, filler.len() - 1)]));
                default: begin
                    if (in_block)
                        put_text(($urandom_range(0, 1) == 0) ? "*" : "**x");
                    else
                        put_text("-/*'\\");
                end
            endcase
        end
    endtask

    task automatic commit_statement(input bit drain_first);
        char_request_t req;
        for (int i = 0; i < stmt_chars.size(); i++) begin
            req.code        = stmt_chars[i];
            req.last        = (i == stmt_chars.size() - 1);
            req.drain_first = drain_first && (i == 0);
            pending_chars.push_back(req);
        end
        total_chars += stmt_chars.size();
        stmt_chars.delete();
    endtask

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        char_request_t next_req;
        if (!aresetn) begin
            s_valid     <= 1'b0;
            s_char_code <= '0;
            s_is_last   <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                scan_sql_char(s_char_code, s_is_last);
                chars_accepted++;
                if (chars_accepted % 97 == 0) begin
                    case ($urandom_range(0, 2))
                        0: gap_pct = 0;
                        1: gap_pct = 15;
                        default: gap_pct = 45;
                    endcase
                end
                if (!winding_down && $urandom_range(0, 99) < gap_pct)
                    gap_left = $urandom_range(1, 18);
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0 || pending_chars.size() == 0 ||
                    (pending_chars[0].drain_first && marker_verdicts.size() != 0)) begin
                    if (gap_left > 0)
                        gap_left--;
                    s_valid <= 1'b0;
                end else begin
                    next_req = pending_chars.pop_front();
                    s_valid     <= 1'b1;
                    s_char_code <= next_req.code;
                    s_is_last   <= next_req.last;
                end
            end
            winding_down <= (pending_chars.size() < TAIL_CHARS);
        end
    end

    // ------------------------------------------------------------------
    // Result monitor and receiver stalls
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        bit expected_found;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                verdicts_seen++;
                if (verdicts_seen % 8 == 0)
                    stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
                if (marker_verdicts.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none, got marker_found=%0b",
                             $time, m_marker_found);
                end else begin
                    expected_found = marker_verdicts.pop_front();
                    if (m_marker_found !== expected_found) begin
                        mismatch_count++;
                        $display("%0t: marker_found mismatch, expected %0b, got %0b",
                                 $time, expected_found, m_marker_found);
                    end
                end
            end
            // one long hold early on so the block backs up and stalls its input
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!hold_done && verdicts_seen >= 5) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!winding_down && $urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(1, 18) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        string wordset;
        int    stmt_count;
        wordset    = "SELECT a,b FROM t WHERE x=1;()\t";
        stmt_count = 0;

        // extremes of the code, cut-off opener at the end, marker in a block comment
        put_code(16'hFFFF);
        commit_statement(1'b0);
        put_code(16'h0000);
        commit_statement(1'b0);
        put_code(CH_DASH);
        commit_statement(1'b0);
        put_text("/*");
        put_marker(MARKER_LEN);
        put_text("*/");
        commit_statement(1'b0);

        while (total_chars < TARGET_CHARS) begin
            repeat ($urandom_range(1, 5)) begin
                case ($urandom_range(0, 9))
                    0, 1: repeat ($urandom_range(1, 6))
                        put_code(CODE_W'(wordset[$urandom_range(0, wordset.len() - 1)]));
                    2, 3: begin
                        put_text("--");
                        put_comment_body(1'b0);
                        if ($urandom_range(0, 3) != 0)
                            put_code(CH_NEWLINE);
                    end
                    4, 5: begin
                        put_text("/*");
                        put_comment_body(1'b1);
                        if ($urandom_range(0, 3) != 0)
                            put_text("*/");
                    end
                    6: begin
                        put_code(CH_QUOTE);
                        repeat ($urandom_range(0, 4)) begin
                            case ($urandom_range(0, 4))
                                0: put_text("\\'");
                                1: put_text("''");
                                2: put_text("\\\\");
                                3: put_text("--/*");
                                default: put_marker(MARKER_LEN);
                            endcase
                        end
                        if ($urandom_range(0, 3) != 0)
                            put_code(CH_QUOTE);
                    end
                    7: repeat ($urandom_range(1, 4))
                        put_code(CODE_W'($urandom_range(0, 65535)));
                    default: repeat ($urandom_range(1, 3)) begin
                        case ($urandom_range(0, 5))
                            0: put_code(CH_DASH);
                            1: put_code(CH_SLASH);
                            2: put_code(CH_STAR);
                            3: put_code(CH_QUOTE);
                            4: put_code(CH_BSLASH);
                            default: put_code(CH_NEWLINE);
                        endcase
                    end
                endcase
            end
            if (stmt_chars.size() == 0)
                put_code(CODE_W'($urandom_range(0, 65535)));
            stmt_count++;
            // pause the sender now and then until every verdict is back
            commit_statement(total_chars < TARGET_CHARS - 2 * TAIL_CHARS &&
                             (stmt_count == 10 || $urandom_range(0, 39) == 0));
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (chars_accepted != total_chars)
            @(posedge aclk);
        while (marker_verdicts.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
